FILE: src/fvcmr_pkg.sv
// Shared types and constants for the FIFO vertex cache miss ratio unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package fvcmr_pkg;

  localparam int CFG_W     = 6;
  localparam int INDEX_W   = 16;
  localparam int CNT_OUT_W = 24;
  localparam int RATIO_W   = 11;
  localparam int FRAC_BITS = 8;

  localparam logic [CFG_W-1:0]   CACHE_SIZE_RESET = 6'd16;
  localparam logic [RATIO_W-1:0] RATIO_MAX        = 11'd2047;
  localparam int                 TRI_DIV          = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRI,
    ST_RATIO,
    ST_OUT
  } fvcmr_state_t;

  typedef struct packed {
    logic accept;
    logic start_ratio;
    logic load_final;
  } fvcmr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
  } fvcmr_stat_t;

endpackage

FILE: src/fvcmr_div.sv
// Bit-serial restoring divider, one quotient bit per clock.
// Used by the datapath; no package dependencies.
module fvcmr_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DVS_W-1:0];
      end
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: src/fvcmr_dpath.sv
// Datapath: cache entries, parallel compare, counters, divider and output register.
// Depends on fvcmr_pkg and fvcmr_div.
module fvcmr_dpath #(
  parameter int CACHE_DEPTH = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fvcmr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [fvcmr_pkg::INDEX_W-1:0]        in_vertex_index,
  input  logic                                 in_last_index,
  input  fvcmr_pkg::fvcmr_cmd_t                cmd,
  output fvcmr_pkg::fvcmr_stat_t               stat,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [fvcmr_pkg::CNT_OUT_W-1:0]      out_miss_count,
  output logic [fvcmr_pkg::CNT_OUT_W-1:0]      out_index_count,
  output logic                                 out_done_res,
  output logic [fvcmr_pkg::RATIO_W-1:0]        out_miss_ratio,
  output logic                                 out_no_triangles
);
  import fvcmr_pkg::*;

  localparam int PTR_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int SZ_W  = $clog2(CACHE_DEPTH + 1);
  localparam int DW    = COUNT_BITS + FRAC_BITS;
  localparam longint unsigned TRI_RECIP =
    ((64'd1 << (COUNT_BITS + 1)) + 64'(TRI_DIV - 1)) / 64'(TRI_DIV);

  logic [CFG_W-1:0]      cache_size_r;
  logic [INDEX_W-1:0]    entry_r [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] valid_r, valid_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt, ptr_eff;
  logic [COUNT_BITS-1:0] miss_r, miss_nxt, idx_r, idx_nxt;
  logic [SZ_W-1:0]       size_eff;
  logic [CACHE_DEPTH-1:0] match;
  logic                  hit;
  logic                  wr_entry;

  logic                  last_hit_r;
  logic [COUNT_BITS-1:0] last_miss_r, last_idx_r;
  logic                  no_tri_r;

  logic [2*COUNT_BITS-1:0] tri_prod;
  logic [COUNT_BITS-1:0]   tri_cnt;

  logic                  div_start;
  logic [DW-1:0]         div_dividend, div_quotient;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [RATIO_W-1:0]    ratio_sat;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_done_r, out_no_tri_r;
  logic [COUNT_BITS-1:0] out_miss_r, out_idx_r;
  logic [RATIO_W-1:0]    out_ratio_r;
  logic [31:0]           miss_wide, idx_wide;
  logic                  out_free;

  always_comb begin
    if (cache_size_r == '0) begin
      size_eff = SZ_W'(1);
    end else if (int'(cache_size_r) > CACHE_DEPTH) begin
      size_eff = SZ_W'(CACHE_DEPTH);
    end else begin
      size_eff = SZ_W'(cache_size_r);
    end
    if (int'(ptr_r) >= int'(size_eff)) begin
      ptr_eff = '0;
    end else begin
      ptr_eff = ptr_r;
    end
  end

  always_comb begin
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      match[j] = valid_r[j] && (entry_r[j] == in_vertex_index) && (j < int'(size_eff));
    end
    hit = |match;
  end

  always_comb begin
    miss_nxt = miss_r;
    if (!hit && !(&miss_r)) begin
      miss_nxt = miss_r + 1'b1;
    end
    idx_nxt = idx_r;
    if (!(&idx_r)) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (hit) begin
      ptr_nxt = ptr_eff;
    end else if (int'(ptr_eff) + 1 >= int'(size_eff)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_eff + 1'b1;
    end
    wr_entry  = cmd.accept && !in_last_index && !hit;
    valid_nxt = valid_r;
    if (wr_entry) begin
      valid_nxt[ptr_eff] = 1'b1;
    end
  end

  // The triangle count is the index count times a rounded-up reciprocal of three.
  always_comb begin
    tri_prod = {{COUNT_BITS{1'b0}}, last_idx_r} *
               {{COUNT_BITS{1'b0}}, COUNT_BITS'(TRI_RECIP)};
    tri_cnt  = COUNT_BITS'(tri_prod >> (COUNT_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_size_r <= CACHE_SIZE_RESET;
      valid_r      <= '0;
      ptr_r        <= '0;
      miss_r       <= '0;
      idx_r        <= '0;
      no_tri_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        cache_size_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (in_last_index) begin
          valid_r <= '0;
          ptr_r   <= '0;
          miss_r  <= '0;
          idx_r   <= '0;
        end else begin
          valid_r <= valid_nxt;
          ptr_r   <= ptr_nxt;
          miss_r  <= miss_nxt;
          idx_r   <= idx_nxt;
        end
      end
      if (cmd.start_ratio) begin
        no_tri_r <= (tri_cnt == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_entry) begin
      entry_r[ptr_eff] <= in_vertex_index;
    end
    if (cmd.accept && in_last_index) begin
      last_hit_r  <= hit;
      last_miss_r <= miss_nxt;
      last_idx_r  <= idx_nxt;
    end
  end

  always_comb begin
    div_start    = cmd.start_ratio;
    div_dividend = {last_miss_r, FRAC_BITS'(0)};
    div_divisor  = tri_cnt;
  end

  fvcmr_div #(
    .DVD_W(DW),
    .DVS_W(COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quotient),
    .done    (div_done)
  );

  // With fewer than three indices the divisor is zero and the quotient is ignored.
  always_comb begin
    if (div_quotient > DW'(RATIO_MAX)) begin
      ratio_sat = RATIO_MAX;
    end else begin
      ratio_sat = div_quotient[RATIO_W-1:0];
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    if ((cmd.accept && !in_last_index) || cmd.load_final) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !in_last_index) begin
      out_hit_r    <= hit;
      out_miss_r   <= miss_nxt;
      out_idx_r    <= idx_nxt;
      out_done_r   <= 1'b0;
      out_ratio_r  <= '0;
      out_no_tri_r <= 1'b0;
    end else if (cmd.load_final) begin
      out_hit_r    <= last_hit_r;
      out_miss_r   <= last_miss_r;
      out_idx_r    <= last_idx_r;
      out_done_r   <= 1'b1;
      out_ratio_r  <= no_tri_r ? '0 : ratio_sat;
      out_no_tri_r <= no_tri_r;
    end
  end

  assign miss_wide = 32'(out_miss_r);
  assign idx_wide  = 32'(out_idx_r);

  assign stat.out_free = out_free;
  assign stat.div_done = div_done;

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_miss_count   = miss_wide[CNT_OUT_W-1:0];
  assign out_index_count  = idx_wide[CNT_OUT_W-1:0];
  assign out_done_res     = out_done_r;
  assign out_miss_ratio   = out_ratio_r;
  assign out_no_triangles = out_no_tri_r;

endmodule

FILE: src/fvcmr_ctrl.sv
// Controller state machine: input handshake and end-of-sequence divide sequencing.
// Depends on fvcmr_pkg.
module fvcmr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last_index,
  input  fvcmr_pkg::fvcmr_stat_t stat,
  output logic                   in_stall,
  output fvcmr_pkg::fvcmr_cmd_t  cmd
);
  import fvcmr_pkg::*;

  fvcmr_state_t state_r, state_nxt;
  logic         accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_last_index) begin
          state_nxt = ST_TRI;
        end
      end
      ST_TRI: begin
        state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cmd.accept      = 1'b0;
    cmd.start_ratio = 1'b0;
    cmd.load_final  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = !stat.out_free;
        cmd.accept = accept;
      end
      ST_TRI: begin
        cmd.start_ratio = 1'b1;
      end
      ST_RATIO: begin
      end
      ST_OUT: begin
        cmd.load_final = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/fifo_vertex_cache_miss_ratio_unit.sv
// Top level of the FIFO vertex cache miss ratio unit.
// Instantiates fvcmr_ctrl and fvcmr_dpath; depends on fvcmr_pkg.

// A FIFO post-transform vertex cache over a stream of 16-bit indices. An index
// that is not marked last is loaded into the output register at the edge that
// accepts it, so such indices flow at one per cycle while the output side keeps
// up. For the last index of a sequence the triangle count comes from a
// reciprocal multiply, and then a bit-serial divider forms misses over
// triangles, one quotient bit per cycle. Its transaction is loaded in state
// ST_OUT, after ST_TRI and ST_RATIO, and the next index is accepted only back in
// ST_IDLE; a stalled output lengthens both. After the last index the cache and
// the counts are clear; the cache size register keeps its value, and the user
// must write it only while idle, since the block itself does not enforce this.
module fifo_vertex_cache_miss_ratio_unit #(
  parameter int CACHE_DEPTH = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fvcmr_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fvcmr_pkg::INDEX_W-1:0]    in_vertex_index,
  input  logic                             in_last_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [fvcmr_pkg::CNT_OUT_W-1:0]  out_miss_count,
  output logic [fvcmr_pkg::CNT_OUT_W-1:0]  out_index_count,
  output logic                             out_done_res,
  output logic [fvcmr_pkg::RATIO_W-1:0]    out_miss_ratio,
  output logic                             out_no_triangles
);
  import fvcmr_pkg::*;

  fvcmr_cmd_t  cmd;
  fvcmr_stat_t stat;

  fvcmr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_index(in_last_index),
    .stat         (stat),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  fvcmr_dpath #(
    .CACHE_DEPTH(CACHE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_vertex_index (in_vertex_index),
    .in_last_index   (in_last_index),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_miss_count  (out_miss_count),
    .out_index_count (out_index_count),
    .out_done_res    (out_done_res),
    .out_miss_ratio  (out_miss_ratio),
    .out_no_triangles(out_no_triangles)
  );

endmodule
